// ===== rtl/json_string_unescape_utf8_unit_macros.svh =====
// Assertion helpers shared by the string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define JSU_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every clock edge outside reset.
`define JSU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define JSU_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define JSU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

  // Payload of one input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // Payload of one result.
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       last;
  } out_item_t;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd2;
  localparam logic [3:0] ERR_CONTROL      = 4'd3;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd5;
  localparam logic [3:0] ERR_SHORT_HEX    = 4'd6;
  localparam logic [3:0] ERR_MISSING_LOW  = 4'd7;
  localparam logic [3:0] ERR_INVALID_LOW  = 4'd8;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd9;

  // Character codes the parser looks for.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_CONTROL_END = 8'h20;

  // Decoded control bytes of the simple escapes.
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  // Top six bits of high and low surrogate code units.
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

  // Command that the parser hands to the UTF-8 writer.
  typedef enum logic [1:0] {
    CMD_RAW   = 2'd0,
    CMD_CP    = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_ERR   = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [20:0] value;
    logic [3:0]  err;
  } cmd_t;

  // Returns {is_hex, value} for one ASCII character, either letter case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

endpackage

// ===== rtl/jsu_front.sv =====
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jsu_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output jsu_pkg::cmd_t     cmd
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_BODY   = 7'b0000010,
    PH_ESC    = 7'b0000100,
    PH_HEX1   = 7'b0001000,
    PH_LOW_BS = 7'b0010000,
    PH_LOW_U  = 7'b0100000,
    PH_HEX2   = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] code_unit_r, code_unit_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic        accept;
  logic [7:0]  c;
  logic        eoi;
  logic [4:0]  hex;
  logic [15:0] cu_full;
  logic        fail;
  logic [3:0]  err;

  // The parser takes a request whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c        = in_data.in_byte;
  assign eoi      = in_data.end_of_input;
  assign hex      = hex_decode(c);
  assign cu_full  = {code_unit_r[11:0], hex[3:0]};

  // Parser state machine: classifies one byte per cycle, while the queue has room, into a command.
  always_comb begin
    phase_nxt     = phase_r;
    hex_count_nxt = hex_count_r;
    code_unit_nxt = code_unit_r;
    hs_nxt        = hs_r;
    fail          = 1'b0;
    err           = ERR_NONE;
    push          = 1'b0;
    cmd           = '0;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (eoi || c != CH_QUOTE) begin
            fail = 1'b1;
            err  = ERR_NO_QUOTE;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (eoi) begin
            fail = 1'b1;
            err  = ERR_UNTERMINATED;
          end else if (c == CH_QUOTE) begin
            phase_nxt = PH_IDLE;
            push      = 1'b1;
            cmd.op    = CMD_CLOSE;
          end else if (c < CH_CONTROL_END) begin
            fail = 1'b1;
            err  = ERR_CONTROL;
          end else if (c == CH_BACKSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            push      = 1'b1;
            cmd.op    = CMD_RAW;
            cmd.value = {13'd0, c};
          end
        end
        PH_ESC: begin
          if (eoi) begin
            fail = 1'b1;
            err  = ERR_BAD_ESCAPE;
          end else begin
            phase_nxt = PH_BODY;
            push      = 1'b1;
            cmd.op    = CMD_RAW;
            unique case (c)
              CH_QUOTE, CH_BACKSLASH, CH_SLASH: cmd.value = {13'd0, c};
              CH_LOWER_B: cmd.value = {13'd0, BYTE_BS};
              CH_LOWER_F: cmd.value = {13'd0, BYTE_FF};
              CH_LOWER_N: cmd.value = {13'd0, BYTE_LF};
              CH_LOWER_R: cmd.value = {13'd0, BYTE_CR};
              CH_LOWER_T: cmd.value = {13'd0, BYTE_HT};
              CH_LOWER_U: begin
                push          = 1'b0;
                phase_nxt     = PH_HEX1;
                hex_count_nxt = 2'd0;
                code_unit_nxt = 16'd0;
              end
              default: begin
                push = 1'b0;
                fail = 1'b1;
                err  = ERR_BAD_ESCAPE;
              end
            endcase
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (eoi) begin
            fail = 1'b1;
            err  = ERR_SHORT_HEX;
          end else if (!hex[4]) begin
            fail = 1'b1;
            err  = ERR_BAD_HEX;
          end else if (hex_count_r != 2'd3) begin
            hex_count_nxt = hex_count_r + 2'd1;
            code_unit_nxt = cu_full;
          end else begin
            // Fourth digit: the code unit is complete.
            hex_count_nxt = 2'd0;
            code_unit_nxt = 16'd0;
            if (phase_r == PH_HEX1) begin
              if (cu_full[15:10] == SURR_HIGH_TAG) begin
                hs_nxt    = cu_full[9:0];
                phase_nxt = PH_LOW_BS;
              end else if (cu_full[15:10] == SURR_LOW_TAG) begin
                fail = 1'b1;
                err  = ERR_LONE_LOW;
              end else begin
                phase_nxt = PH_BODY;
                push      = 1'b1;
                cmd.op    = CMD_CP;
                cmd.value = {5'd0, cu_full};
              end
            end else begin
              if (cu_full[15:10] != SURR_LOW_TAG) begin
                fail = 1'b1;
                err  = ERR_INVALID_LOW;
              end else begin
                phase_nxt = PH_BODY;
                push      = 1'b1;
                cmd.op    = CMD_CP;
                cmd.value = SUPPLEMENTARY_BASE + {1'b0, hs_r, cu_full[9:0]};
              end
            end
          end
        end
        PH_LOW_BS: begin
          if (eoi || c != CH_BACKSLASH) begin
            fail = 1'b1;
            err  = ERR_MISSING_LOW;
          end else begin
            phase_nxt = PH_LOW_U;
          end
        end
        PH_LOW_U: begin
          if (eoi || c != CH_LOWER_U) begin
            fail = 1'b1;
            err  = ERR_MISSING_LOW;
          end else begin
            phase_nxt     = PH_HEX2;
            hex_count_nxt = 2'd0;
            code_unit_nxt = 16'd0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // Any error drops back to waiting for an opening quote.
      if (fail) begin
        phase_nxt     = PH_IDLE;
        hex_count_nxt = 2'd0;
        code_unit_nxt = 16'd0;
        push          = 1'b1;
        cmd.op        = CMD_ERR;
        cmd.value     = '0;
        cmd.err       = err;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hex_count_r <= 2'd0;
    end else begin
      phase_r     <= phase_nxt;
      hex_count_r <= hex_count_nxt;
    end
  end

  // Gathered hex value and saved high surrogate.
  always_ff @(posedge clk) begin
    code_unit_r <= code_unit_nxt;
    hs_r        <= hs_nxt;
  end

endmodule

// ===== rtl/jsu_queue.sv =====
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  input  logic          pop,
  output jsu_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import jsu_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty = (count_r == CW'(0));
  assign full  = (count_r == CW'(DEPTH));
  assign head  = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `JSU_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full, "command queue overflow")
  `JSU_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty, "command queue underflow")
  `JSU_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !empty, "pushed entry vanished")

endmodule

// ===== rtl/jsu_back.sv =====
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::cmd_t      head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_data
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic [1:0] last_idx;
  logic [1:0] sel;
  logic [5:0] chunk;
  logic [7:0] byte_val;
  logic       load;

  // Number of bytes the head command expands to, minus one.
  always_comb begin
    last_idx = 2'd0;
    if (head.op == CMD_CP) begin
      if (head.value <= 21'h7F) begin
        last_idx = 2'd0;
      end else if (head.value <= 21'h7FF) begin
        last_idx = 2'd1;
      end else if (head.value <= 21'hFFFF) begin
        last_idx = 2'd2;
      end else begin
        last_idx = 2'd3;
      end
    end
  end

  // Picks the UTF-8 byte at position idx_r of the head code point.
  assign sel = last_idx - idx_r;

  always_comb begin
    case (sel)
      2'd0:    chunk = head.value[5:0];
      2'd1:    chunk = head.value[11:6];
      default: chunk = head.value[17:12];
    endcase
    if (idx_r == 2'd0) begin
      case (last_idx)
        2'd0:    byte_val = head.value[7:0];
        2'd1:    byte_val = {3'b110, head.value[10:6]};
        2'd2:    byte_val = {4'b1110, head.value[15:12]};
        default: byte_val = {5'b11110, head.value[20:18]};
      endcase
    end else begin
      byte_val = {2'b10, chunk};
    end
  end

  // Output register loads when empty or when its result is being taken.
  assign load = !out_valid_r || !out_stall;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_data_nxt            = '0;
        out_data_nxt.last       = (idx_r == last_idx);
        case (head.op)
          CMD_RAW, CMD_CP: begin
            out_data_nxt.result_kind = KIND_BYTE;
            out_data_nxt.out_byte    = byte_val;
          end
          CMD_CLOSE: begin
            out_data_nxt.result_kind = KIND_CLOSE;
          end
          default: begin
            out_data_nxt.result_kind = KIND_ERROR;
            out_data_nxt.error_code  = head.err;
          end
        endcase
        if (idx_r == last_idx) begin
          pop     = 1'b1;
          idx_nxt = 2'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `JSU_ASSERT_IMPLY(a_idx_in_range, clk, rst_n, !q_empty, idx_r <= last_idx, "byte index past end")
  `JSU_ASSERT_IMPLY(a_multi_only_cp, clk, rst_n, idx_r != 2'd0, !q_empty && head.op == CMD_CP,
                    "multi-byte output without a code point")

endmodule

// ===== rtl/json_string_unescape_utf8_unit.sv =====
// JSON string unescape unit: one raw text byte in, decoded UTF-8 bytes out.
// Input channel in_valid/in_stall/in_data carries one byte per request, or an
// end-of-input marker. A request is taken at a clock edge with in_valid high
// and in_stall low. Result channel out_valid/out_stall/out_data carries zero or
// more results per request: a decoded byte, a string-closed mark or an error code,
// with last set on the final result that an input byte causes.
// Throughput: one input byte per cycle while the queue has room. The writer
// sends one result per cycle while out_stall is low, so a \u escape that
// expands to two to four UTF-8 bytes holds the writer for all of them; the
// command queue between parser and writer absorbs this and in_stall rises only when it is full.
// A result is written into the command queue and then into the output register
// before out_valid rises for it.
// Reset (rst_n low, synchronous) empties the queue and the output register and
// returns the parser to waiting for an opening quote.
// When out_stall is high the current result holds; the parser keeps taking
// bytes until the queue fills.
module json_string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_data
);
  import jsu_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  // Parser: classifies input bytes into commands.
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Command queue between parser and writer.
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Writer: expands commands into UTF-8 bytes and results.
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/json_string_unescape_utf8_unit_test.sv =====
`timescale 1ns / 100ps

module json_string_unescape_utf8_unit_test;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 220;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;

  // Scanner states of the decoder, in the order the block walks them.
  typedef enum logic [2:0] {
    ST_WAIT_QUOTE,
    ST_BODY,
    ST_ESCAPE,
    ST_HEX_FIRST,
    ST_LOW_BSLASH,
    ST_LOW_U,
    ST_HEX_LOW
  } scan_state_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  // Raw text still to be sent, and the decoded results still owed by the block.
  in_item_t text_q[$];
  out_item_t decoded_q[$];
  out_item_t step_res[$];

  // Decoder state mirrored on the testbench side.
  scan_state_t scan_st;
  logic [1:0] digit_cnt;
  logic [15:0] unit_acc;
  logic [9:0] high_bits;

  int in_count;
  int total_items;
  int fail_cnt;
  int quiet_cycles;
  int send_gap;
  int stall_left;
  int hold_left;
  bit hold_done;
  bit in_taken;
  out_item_t want_res;

  json_string_unescape_utf8_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Value of one hex digit in either letter case, or -1.
  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic add_result(input logic [1:0] kind, input logic [7:0] b,
                            input logic [3:0] code);
    out_item_t r;
    r.result_kind = kind;
    r.out_byte = b;
    r.error_code = code;
    r.last = 1'b0;
    step_res.insert(step_res.size(), r);
  endtask

  // Any error drops the string and sends the scanner back to the opening quote.
  task automatic add_error(input logic [3:0] code);
    scan_st = ST_WAIT_QUOTE;
    digit_cnt = 2'd0;
    unit_acc = 16'h0000;
    add_result(KIND_ERROR, 8'h00, code);
  endtask

  // UTF-8 encoding of one code point, one to four bytes.
  task automatic add_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(KIND_BYTE, cp[7:0], ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      add_result(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NONE);
      add_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      add_result(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NONE);
      add_result(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
      add_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end else begin
      add_result(KIND_BYTE, {5'b11110, cp[20:18]}, ERR_NONE);
      add_result(KIND_BYTE, {2'b10, cp[17:12]}, ERR_NONE);
      add_result(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
      add_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end
  endtask

  // Decodes one accepted request and queues the results it should cause.
  task automatic decode_request(input in_item_t req);
    logic [7:0] c;
    logic eoi;
    logic [15:0] cu;
    logic unit_done;
    int hv;
    c = req.in_byte;
    eoi = req.end_of_input;
    cu = 16'h0000;
    unit_done = 1'b0;
    step_res.delete();
    case (scan_st)
      ST_WAIT_QUOTE: begin
        if (eoi || c != CH_QUOTE) add_error(ERR_NO_QUOTE);
        else scan_st = ST_BODY;
      end
      ST_BODY: begin
        if (eoi) begin
          add_error(ERR_UNTERMINATED);
        end else if (c == CH_QUOTE) begin
          scan_st = ST_WAIT_QUOTE;
          add_result(KIND_CLOSE, 8'h00, ERR_NONE);
        end else if (c < CH_CONTROL_END) begin
          add_error(ERR_CONTROL);
        end else if (c == CH_BACKSLASH) begin
          scan_st = ST_ESCAPE;
        end else begin
          add_result(KIND_BYTE, c, ERR_NONE);
        end
      end
      ST_ESCAPE: begin
        if (eoi) begin
          add_error(ERR_BAD_ESCAPE);
        end else begin
          scan_st = ST_BODY;
          case (c)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: add_result(KIND_BYTE, c, ERR_NONE);
            CH_LOWER_B: add_result(KIND_BYTE, BYTE_BS, ERR_NONE);
            CH_LOWER_F: add_result(KIND_BYTE, BYTE_FF, ERR_NONE);
            CH_LOWER_N: add_result(KIND_BYTE, BYTE_LF, ERR_NONE);
            CH_LOWER_R: add_result(KIND_BYTE, BYTE_CR, ERR_NONE);
            CH_LOWER_T: add_result(KIND_BYTE, BYTE_HT, ERR_NONE);
            CH_LOWER_U: begin
              scan_st = ST_HEX_FIRST;
              digit_cnt = 2'd0;
              unit_acc = 16'h0000;
            end
            default: add_error(ERR_BAD_ESCAPE);
          endcase
        end
      end
      ST_HEX_FIRST, ST_HEX_LOW: begin
        hv = hex_val(c);
        if (eoi) begin
          add_error(ERR_SHORT_HEX);
        end else if (hv < 0) begin
          add_error(ERR_BAD_HEX);
        end else begin
          unit_acc = {unit_acc[11:0], hv[3:0]};
          if (digit_cnt == 2'd3) begin
            digit_cnt = 2'd0;
            cu = unit_acc;
            unit_acc = 16'h0000;
            unit_done = 1'b1;
          end else begin
            digit_cnt = digit_cnt + 2'd1;
          end
        end
        // A complete first unit is either a plain code point or half of a pair.
        if (unit_done && scan_st == ST_HEX_FIRST) begin
          if (cu[15:10] == SURR_HIGH_TAG) begin
            high_bits = cu[9:0];
            scan_st = ST_LOW_BSLASH;
          end else if (cu[15:10] == SURR_LOW_TAG) begin
            add_error(ERR_LONE_LOW);
          end else begin
            scan_st = ST_BODY;
            add_utf8({5'd0, cu});
          end
        end else if (unit_done) begin
          if (cu[15:10] != SURR_LOW_TAG) begin
            add_error(ERR_INVALID_LOW);
          end else begin
            scan_st = ST_BODY;
            add_utf8(SUPPLEMENTARY_BASE + {1'b0, high_bits, cu[9:0]});
          end
        end
      end
      ST_LOW_BSLASH: begin
        if (eoi || c != CH_BACKSLASH) add_error(ERR_MISSING_LOW);
        else scan_st = ST_LOW_U;
      end
      ST_LOW_U: begin
        if (eoi || c != CH_LOWER_U) begin
          add_error(ERR_MISSING_LOW);
        end else begin
          scan_st = ST_HEX_LOW;
          digit_cnt = 2'd0;
          unit_acc = 16'h0000;
        end
      end
      default: scan_st = ST_WAIT_QUOTE;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) decoded_q.insert(decoded_q.size(), step_res[i]);
  endtask

  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it.in_byte = b;
    it.end_of_input = 1'b0;
    text_q.insert(text_q.size(), it);
  endtask

  // End of input carries a random byte that the block must ignore.
  task automatic push_eoi();
    in_item_t it;
    it.in_byte = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    text_q.insert(text_q.size(), it);
  endtask

  task automatic push_hex_digit(input logic [3:0] v);
    if (v < 4'd10) push_byte(8'h30 + {4'd0, v});
    else push_byte(($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10);
  endtask

  task automatic push_hex_unit(input logic [15:0] u);
    push_byte(CH_BACKSLASH);
    push_byte(CH_LOWER_U);
    for (int i = 3; i >= 0; i--) push_hex_digit(u[i * 4 +: 4]);
  endtask

  // A backslash-u followed by fewer than four digits.
  task automatic push_partial_unit(input int n_digits);
    push_byte(CH_BACKSLASH);
    push_byte(CH_LOWER_U);
    repeat (n_digits) push_hex_digit(4'($urandom_range(0, 15)));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range('h20, 'hFF));
    while (b == CH_QUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  function automatic logic [7:0] escape_letter(input int sel);
    case (sel)
      0: return CH_QUOTE;
      1: return CH_BACKSLASH;
      2: return CH_SLASH;
      3: return CH_LOWER_B;
      4: return CH_LOWER_F;
      5: return CH_LOWER_N;
      6: return CH_LOWER_R;
      default: return CH_LOWER_T;
    endcase
  endfunction

  // Basic-plane code unit outside the surrogate range, spread over 1 to 3 byte forms.
  function automatic logic [15:0] bmp_unit();
    logic [15:0] u;
    case ($urandom_range(0, 2))
      0: u = 16'($urandom_range(0, 'h7F));
      1: u = 16'($urandom_range('h80, 'h7FF));
      default: u = 16'($urandom_range('h800, 'hFFFF));
    endcase
    if (u[15:11] == 5'b11011) u[14] = 1'b0;
    return u;
  endfunction

  function automatic logic [15:0] high_unit();
    return 16'hD800 | 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] low_unit();
    return 16'hDC00 | 16'($urandom_range(0, 1023));
  endfunction

  // Ends a string with one of the malformed endings.
  task automatic push_broken_tail();
    logic [15:0] u;
    case ($urandom_range(0, 9))
      0: push_eoi();
      1: push_byte(8'($urandom_range(0, 'h1F)));
      2: begin
        push_byte(CH_BACKSLASH);
        push_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        push_byte(CH_BACKSLASH);
        push_eoi();
      end
      4: begin
        push_partial_unit($urandom_range(0, 3));
        push_byte($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 255)));
      end
      5: begin
        push_partial_unit($urandom_range(0, 3));
        push_eoi();
      end
      6: begin
        push_hex_unit(high_unit());
        case ($urandom_range(0, 3))
          0: push_eoi();
          1: push_byte(8'($urandom_range(0, 255)));
          2: begin
            push_byte(CH_BACKSLASH);
            push_byte(8'($urandom_range(0, 255)));
          end
          default: begin
            push_byte(CH_BACKSLASH);
            push_eoi();
          end
        endcase
      end
      7: begin
        push_hex_unit(high_unit());
        u = 16'($urandom_range(0, 'hFFFF));
        if (u[15:10] == SURR_LOW_TAG) u[15] = 1'b0;
        push_hex_unit(u);
      end
      8: push_hex_unit(low_unit());
      default: begin
        push_hex_unit(high_unit());
        push_partial_unit($urandom_range(0, 3));
        if ($urandom_range(0, 1)) push_eoi();
        else push_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // One string: mostly well formed with random content, some noise and broken endings.
  task automatic push_random_string();
    int n_tok;
    int sel;
    if ($urandom_range(0, 15) == 0) begin
      if ($urandom_range(0, 1)) push_eoi();
      else push_byte(8'($urandom_range(0, 255)));
    end
    push_byte(CH_QUOTE);
    n_tok = $urandom_range(0, 6);
    repeat (n_tok) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        push_byte(plain_byte());
      end else if (sel < 6) begin
        push_byte(CH_BACKSLASH);
        push_byte(escape_letter($urandom_range(0, 7)));
      end else if (sel < 8) begin
        push_hex_unit(bmp_unit());
      end else begin
        push_hex_unit(high_unit());
        push_hex_unit(low_unit());
      end
    end
    if ($urandom_range(0, 3) != 0) push_byte(CH_QUOTE);
    else push_broken_tail();
  endtask

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string fname, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_cnt++;
      if (fail_cnt < 50)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want_v, got_v);
    end
  endtask

  // Request driver: presents the next byte once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        in_data <= text_q.pop_front();
        in_valid <= 1'b1;
        // Keep offering without gaps around the long receiver hold.
        send_gap = (in_count >= 70 && in_count < 100) ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random gaps, one long hold, and a window with no stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && in_count >= 80) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (in_count >= 150 && in_count < 200) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_len();
        out_stall <= 1'b0;
      end
    end
  end

  // Accepted requests feed the decoder model.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      decode_request(in_data);
      in_count++;
    end
  end

  // Result monitor: each accepted result against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt < 50)
          $display("%0t: unexpected result: expected none, actual kind %0d byte %0d err %0d last %0d",
                   $time, out_data.result_kind, out_data.out_byte, out_data.error_code,
                   out_data.last);
      end else begin
        want_res = decoded_q.pop_front();
        check_field("result_kind", want_res.result_kind, out_data.result_kind);
        check_field("out_byte", want_res.out_byte, out_data.out_byte);
        check_field("error_code", want_res.error_code, out_data.error_code);
        check_field("last", want_res.last, out_data.last);
      end
    end
  end

  // Watchdog on cycles where neither channel moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    in_count = 0;
    fail_cnt = 0;
    quiet_cycles = 0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    in_taken = 1'b0;
    scan_st = ST_WAIT_QUOTE;
    digit_cnt = 2'd0;
    unit_acc = 16'h0000;
    high_bits = 10'd0;

    // Directed: input ending before any quote, extreme bytes, escaped NUL,
    // the highest code point, a raw control byte and a stray byte while waiting.
    push_eoi();
    push_byte(CH_QUOTE);
    push_byte(8'hFF);
    push_byte(CH_CONTROL_END);
    push_hex_unit(16'h0000);
    push_hex_unit(16'hDBFF);
    push_hex_unit(16'hDFFF);
    push_byte(CH_QUOTE);
    push_byte(CH_QUOTE);
    push_byte(8'h1F);
    push_byte(8'h00);

    // Random strings.
    total_items = RANDOM_ITEMS;
    while (text_q.size() < total_items) push_random_string();
    total_items = text_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (in_count < total_items) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
